### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ured_pkg.sv
// ---------------------------------------------------------------------------
// ured_pkg
// Types and constants shared by the receive deframer modules.
// ---------------------------------------------------------------------------
package ured_pkg;

  localparam int LEN_BITS     = 11;  // header length field width; lengths 1..2047
  localparam int OUT_LEN_BITS = 11;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SKIP    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       transfer_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0]              payload_byte;
    logic                    frame_end;
    logic [OUT_LEN_BITS-1:0] frame_length;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } q_wr_t;

endpackage

### rtl/usb_ethernet_rx_deframer_unit.sv
// ---------------------------------------------------------------------------
// usb_ethernet_rx_deframer_unit
// Splits a bulk-in byte stream into length/check headed frames.
// ---------------------------------------------------------------------------
// Input side is a queue write port: a byte with its end-of-transfer flag is
// taken at each edge where push is high and full is low. Result side is a
// queue read port: while empty is low the oldest payload word (byte,
// frame-end flag, frame length) sits on result and leaves when pop is high.
// Header bytes, dropped frames and skipped bytes give no result.
// One byte is taken per cycle while full is low. The parser writes a
// payload word into a four-word queue on the edge that takes its byte;
// the output register loads it once it heads the queue and the register
// is free or being popped. Queue and output register together hold five
// words; full rises only when the queue itself is full, i.e. after the
// consumer has held off pop long enough to fill it, and the parser stalls
// in place.
// Synchronous reset returns the parser to the header phase and empties the
// queue and output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module usb_ethernet_rx_deframer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ured_pkg::in_word_t   item,
  input  logic                 pop,
  output logic                 empty,
  output ured_pkg::out_word_t  result
);
  import ured_pkg::*;

  q_wr_t     wr;
  out_word_t rd_word;
  logic      rd, q_full, q_empty, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  ured_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .accept (accept),
    .wr     (wr)
  );

  ured_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rd_word (rd_word)
  );

  ured_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .rd_word (rd_word),
    .rd      (rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

### rtl/ured_front.sv
// ---------------------------------------------------------------------------
// ured_front
// Header parser: gathers the 4-byte header, checks it and tags payload bytes.
// ---------------------------------------------------------------------------
module ured_front (
  input  logic             clk,
  input  logic             rst,
  input  ured_pkg::in_word_t item,
  input  logic             accept,
  output ured_pkg::q_wr_t  wr
);
  import ured_pkg::*;

  phase_t              phase, phase_next;
  logic [1:0]          header_count, header_count_next;
  logic [23:0]         header_bytes, header_bytes_next;
  logic [LEN_BITS-1:0] remaining, remaining_next;
  logic [LEN_BITS-1:0] cur_len, cur_len_next;

  logic [LEN_BITS-1:0] hdr_len, hdr_inv, rem_dec;
  logic [15:0]         chk;

  assign hdr_len = header_bytes[LEN_BITS-1:0];
  assign chk     = {item.data_byte, header_bytes[23:16]};
  assign hdr_inv = ~chk[LEN_BITS-1:0];
  assign rem_dec = remaining - LEN_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 2'd0;
      header_bytes <= '0;
      remaining    <= '0;
      cur_len      <= '0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      header_bytes <= header_bytes_next;
      remaining    <= remaining_next;
      cur_len      <= cur_len_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    header_bytes_next      = header_bytes;
    remaining_next         = remaining;
    cur_len_next           = cur_len;
    wr.valid               = 1'b0;
    wr.word.payload_byte   = item.data_byte;
    wr.word.frame_end      = (rem_dec == '0);
    wr.word.frame_length   = OUT_LEN_BITS'(cur_len);
    if (accept) begin
      case (phase)
        PH_PAYLOAD: begin
          wr.valid       = 1'b1;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next        = PH_HEADER;
            header_count_next = 2'd0;
            header_bytes_next = '0;
          end
        end
        PH_SKIP: begin
          if (item.transfer_end) begin
            phase_next        = PH_HEADER;
            header_count_next = 2'd0;
            header_bytes_next = '0;
          end
        end
        default: begin
          // unused phase code behaves as header
          phase_next = PH_HEADER;
          if (header_count != 2'd3) begin
            case (header_count)
              2'd0:    header_bytes_next[7:0]   = item.data_byte;
              2'd1:    header_bytes_next[15:8]  = item.data_byte;
              default: header_bytes_next[23:16] = item.data_byte;
            endcase
            header_count_next = header_count + 2'd1;
            if (item.transfer_end) begin
              header_count_next = 2'd0;
              header_bytes_next = '0;
            end
          end else begin
            header_count_next = 2'd0;
            header_bytes_next = '0;
            if (hdr_len == '0 || hdr_len != hdr_inv) begin
              phase_next = item.transfer_end ? PH_HEADER : PH_SKIP;
            end else begin
              cur_len_next   = hdr_len;
              remaining_next = hdr_len;
              phase_next     = PH_PAYLOAD;
            end
          end
        end
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_pay_nonzero, clk, rst, (phase != PH_PAYLOAD) || (remaining != '0), "payload phase with nothing left")
  `ASSERT_NEXT(a_frame_close, clk, rst, wr.valid && wr.word.frame_end, (phase == PH_HEADER) && (header_count == 2'd0), "frame end did not return to header")

endmodule

### rtl/ured_queue.sv
// ---------------------------------------------------------------------------
// ured_queue
// Short flop queue between the header parser and the output stage.
// ---------------------------------------------------------------------------
module ured_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  ured_pkg::q_wr_t      wr,
  input  logic                 rd,
  output logic                 q_full,
  output logic                 q_empty,
  output ured_pkg::out_word_t  rd_word
);
  import ured_pkg::*;

  out_word_t            entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign q_full  = (count == QCNT_BITS'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      entries[wr_ptr] <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({wr.valid, rd})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(wr.valid && q_full), "write into full queue")
  `ASSERT_ALWAYS(a_no_underflow, clk, rst, !(rd && q_empty), "read from empty queue")

endmodule

### rtl/ured_back.sv
// ---------------------------------------------------------------------------
// ured_back
// Output stage: holds the oldest word for the consumer, refills from queue.
// ---------------------------------------------------------------------------
module ured_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  ured_pkg::out_word_t  rd_word,
  output logic                 rd,
  input  logic                 pop,
  output logic                 empty,
  output ured_pkg::out_word_t  result
);
  import ured_pkg::*;

  logic      out_valid;
  out_word_t out_word;

  // refill when the register is free or being taken this cycle
  assign rd     = !q_empty && (!out_valid || pop);
  assign empty  = !out_valid;
  assign result = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      out_word <= rd_word;
    end
  end

endmodule
